### design/esh_pkg.sv
`default_nettype none

package esh_pkg;

    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 17;
    localparam int TABLE_ENTRIES_DEF = 8 << 10;
    localparam int PROBE_COUNT_DEF   = 4;

    localparam logic [DATA_W-1:0]  MIX_XOR   = 32'd61;
    localparam logic [DATA_W-1:0]  MIX_MUL   = 32'h27d4eb2d;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd65536;

    // smallest power of two (at least two) that holds every probe in its own bank
    function automatic int bank_count(input int probes);
        int n;
        n = 2;
        while (n < probes) begin
            n = n * 2;
        end
        return n;
    endfunction

    // first half of the pc hash: xor, shift-add and xor-shift
    function automatic logic [DATA_W-1:0] mix_pre(input logic [DATA_W-1:0] a);
        logic [DATA_W-1:0] t;
        t = (a ^ MIX_XOR) ^ (a >> 16);
        t = t + (t << 3);
        t = t ^ (t >> 4);
        return t;
    endfunction

    // second half: multiply and fold down
    function automatic logic [DATA_W-1:0] mix_post(input logic [DATA_W-1:0] a);
        logic [DATA_W-1:0] t;
        t = a * MIX_MUL;
        t = t ^ (t >> 15);
        return t;
    endfunction

endpackage

`default_nettype wire

### design/edge_signal_hash_dedup_top.sv
`default_nettype none

// Edge signal former with seen-signal deduplication.
// Input channel (in_valid/in_ready): one traced pc per transaction, with
// first_of_call marking the start of a new call; that clears the previous
// hash and the per-call count of new signals.
// Output channel (out_valid/out_ready): one transaction per new edge signal,
// carrying the signal (pc xor hash of the previous pc) and the running count
// of new signals in the call, saturating at 65536. Seen signals give nothing.
// A new pc waits for the lookup of the last one, set by the read-then-write-back of
// the banked seen table (all probe slots read together, one slot written).
// An accepted pc goes through ST_LOOK, then into the output register.
// The output register parts the two sides: a new item is taken while a
// result waits only if that result is taken in the same cycle; a stalled
// receiver otherwise holds the input channel.
// Reset: control state clears at once, then a clearing pass zeroes the
// table one row per cycle over TABLE_ENTRIES / banks rows (2048 with the
// default sizes); in_ready stays low for that pass.
// TABLE_ENTRIES must be a power of two.
module edge_signal_hash_dedup_top #(
    parameter int TABLE_ENTRIES = esh_pkg::TABLE_ENTRIES_DEF,
    parameter int PROBE_COUNT   = esh_pkg::PROBE_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [esh_pkg::DATA_W-1:0]     pc,
    input  wire logic                           first_of_call,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [esh_pkg::DATA_W-1:0]          signal,
    output logic [esh_pkg::COUNT_W-1:0]         new_count
);
    import esh_pkg::*;

    localparam int BANKS  = bank_count(PROBE_COUNT);
    localparam int ROWS   = TABLE_ENTRIES / BANKS;
    localparam int BANK_W = $clog2(BANKS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SLOT_W = BANK_W + ROW_W;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ROW_W-1:0]     clr_row_reg, clr_row_next;
    logic [DATA_W-1:0]    prev_hash_reg, prev_hash_next;
    logic [DATA_W-1:0]    mix_reg, mix_next;
    logic [DATA_W-1:0]    sig_reg, sig_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    signal_reg, signal_next;
    logic [COUNT_W-1:0]   new_count_reg, new_count_next;

    logic                         accept;
    logic [DATA_W-1:0]            sig_in;
    logic [BANKS-1:0][DATA_W-1:0] rd_data;
    logic [SLOT_W-1:0]            home_slot;
    logic [BANK_W-1:0]            home_bank;
    logic                         found;
    logic                         seen;
    logic [BANK_W-1:0]            pick;
    logic [SLOT_W-1:0]            wr_slot;
    logic                         wr_en;
    logic [COUNT_W-1:0]           count_inc;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign sig_in    = pc ^ (first_of_call ? '0 : prev_hash_reg);

    assign out_valid = out_valid_reg;
    assign signal    = signal_reg;
    assign new_count = new_count_reg;

    // probe results: take the first slot that matches or is empty
    assign home_slot = sig_reg[SLOT_W-1:0];
    assign home_bank = sig_reg[BANK_W-1:0];

    always_comb
    begin
        logic [BANK_W-1:0] pbank;
        logic [DATA_W-1:0] d;
        found = 1'b0;
        seen  = 1'b0;
        pick  = '0;
        for (int i = 0; i < PROBE_COUNT; i++) begin
            pbank = home_bank + BANK_W'(i);
            d     = rd_data[pbank];
            if (!found && ((d == sig_reg) || (d == '0))) begin
                found = 1'b1;
                seen  = (d == sig_reg);
                pick  = BANK_W'(i);
            end
        end
    end

    // all probes full: overwrite the home slot
    assign wr_slot   = found ? (home_slot + SLOT_W'(pick)) : home_slot;
    assign wr_en     = (state_reg == ST_LOOK) && !seen;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    esh_table #(
        .BANKS (BANKS),
        .ROWS  (ROWS)
    ) u_table (
        .clk     (clk),
        .rd_en   (accept),
        .rd_home (sig_in[SLOT_W-1:0]),
        .wr_en   (wr_en),
        .wr_slot (wr_slot),
        .wr_data (sig_reg),
        .clr_en  (state_reg == ST_CLEAR),
        .clr_row (clr_row_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        prev_hash_next = prev_hash_reg;
        mix_next       = mix_reg;
        sig_next       = sig_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        signal_next    = signal_reg;
        new_count_next = new_count_reg;

        // drop the waiting result once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_row_next = clr_row_reg + ROW_W'(1);
                if (clr_row_reg == ROW_W'(ROWS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept) begin
                    sig_next   = sig_in;
                    mix_next   = mix_pre(pc);
                    if (first_of_call)
                        count_next = '0;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                prev_hash_next = mix_post(mix_reg);
                if (!seen) begin
                    count_next     = count_inc;
                    out_valid_next = 1'b1;
                    signal_next    = sig_reg;
                    new_count_next = count_inc;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            prev_hash_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            prev_hash_reg <= prev_hash_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg       <= mix_next;
        sig_reg       <= sig_next;
        signal_reg    <= signal_next;
        new_count_reg <= new_count_next;
    end

endmodule

`default_nettype wire

### design/esh_table.sv
`default_nettype none

module esh_table #(
    parameter  int BANKS  = 4,
    parameter  int ROWS   = 2048,
    localparam int BANK_W = $clog2(BANKS),
    localparam int ROW_W  = $clog2(ROWS),
    localparam int SLOT_W = BANK_W + ROW_W
) (
    input  wire logic                                  clk,
    input  wire logic                                  rd_en,
    input  wire logic [SLOT_W-1:0]                     rd_home,
    input  wire logic                                  wr_en,
    input  wire logic [SLOT_W-1:0]                     wr_slot,
    input  wire logic [esh_pkg::DATA_W-1:0]            wr_data,
    input  wire logic                                  clr_en,
    input  wire logic [ROW_W-1:0]                      clr_row,
    output logic [BANKS-1:0][esh_pkg::DATA_W-1:0]      rd_data
);
    import esh_pkg::*;

    logic [BANK_W-1:0] home_bank;
    logic [ROW_W-1:0]  home_row;
    logic [BANK_W-1:0] wr_bank;
    logic [ROW_W-1:0]  wr_row;

    assign home_bank = rd_home[BANK_W-1:0];
    assign home_row  = rd_home[SLOT_W-1:BANK_W];
    assign wr_bank   = wr_slot[BANK_W-1:0];
    assign wr_row    = wr_slot[SLOT_W-1:BANK_W];

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [DATA_W-1:0] mem [ROWS];
        logic [DATA_W-1:0] q_reg;
        logic [ROW_W-1:0]  rd_row;

        // banks below the home bank hold the wrapped probes of the next row
        always_comb
        begin
            if (BANK_W'(b) < home_bank)
                rd_row = home_row + ROW_W'(1);
            else
                rd_row = home_row;
        end

        always_ff @(posedge clk)
        begin
            if (clr_en)
                mem[clr_row] <= '0;
            else if (wr_en && (wr_bank == BANK_W'(b)))
                mem[wr_row] <= wr_data;
            if (rd_en)
                q_reg <= mem[rd_row];
        end

        assign rd_data[b] = q_reg;
    end

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

// One transaction on the input channel carries one pc. The driver feeds these
// from a backlog that the stimulus block fills. At each accepted input
// transaction the driver works out the edge signal, updates its own copy of
// the seen-signal table and queues the new edge, if there is one, for the
// monitor. The monitor matches every output transaction against the oldest
// queued edge.
module tb_top;
    import esh_pkg::*;

    localparam int TABLE_N     = TABLE_ENTRIES_DEF;
    localparam int PROBES      = PROBE_COUNT_DEF;
    localparam int RANDOM_PCS  = 820;
    // covers the table clearing pass after reset plus the longest gap and stall
    localparam int STALL_LIMIT = 20000;
    localparam int LIB_N       = 8;
    localparam int LIB_LEN     = 16;

    typedef struct {
        logic [DATA_W-1:0] pc;
        logic              first;
        bit                quiet;   // no idling on either side around this pc
    } pc_item_t;

    typedef struct {
        logic [DATA_W-1:0]  sig;
        logic [COUNT_W-1:0] cnt;
    } new_edge_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [DATA_W-1:0]    pc = '0;
    logic                 first_of_call = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DATA_W-1:0]    signal;
    logic [COUNT_W-1:0]   new_count;

    // pcs waiting to be driven, and edges waiting to come out
    pc_item_t             pc_backlog[$];
    new_edge_t            fresh_edges[$];
    int                   queued_pcs = 0;
    int                   accepted_pcs = 0;
    int                   mismatches = 0;
    int                   quiet_cycles = 0;

    // shadow state of the block
    logic [DATA_W-1:0]    chain_hash;
    logic [COUNT_W-1:0]   call_new;
    logic [DATA_W-1:0]    seen_sigs [TABLE_N];

    // idling control
    int                   in_gap;
    int                   out_stall;
    logic                 calm = 1'b1;

    edge_signal_hash_dedup_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pc            (pc),
        .first_of_call (first_of_call),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .signal        (signal),
        .new_count     (new_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Integer hash of a pc; the shift-add step is a multiply by nine.
    function automatic logic [DATA_W-1:0] pc_hash(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] h;
        h = v ^ MIX_XOR ^ (v >> 16);
        h = h * 32'd9;
        h = h ^ (h >> 4);
        h = h * MIX_MUL;
        return h ^ (h >> 15);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    task automatic queue_pc(input logic [DATA_W-1:0] p, input logic f, input bit q);
        pc_backlog.push_back('{p, f, q});
        queued_pcs++;
    endtask

    // Driver and shadow model. Hold the payload until the transaction is taken;
    // only then apply the model to it and move on to a gap or the next pc.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic [DATA_W-1:0] sig;
        logic [DATA_W-1:0] probe;
        int                slot;
        bit                seen;
        bit                stored;
        pc_item_t          nxt;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            pc            <= '0;
            first_of_call <= 1'b0;
            calm          <= 1'b1;
            in_gap         = 0;
            chain_hash     = '0;
            call_new       = '0;
            for (int i = 0; i < TABLE_N; i++)
                seen_sigs[i] = '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                accepted_pcs++;
                if (first_of_call)
                begin
                    chain_hash = '0;
                    call_new   = '0;
                end
                sig        = pc ^ chain_hash;
                chain_hash = pc_hash(pc);
                // a zero signal looks like an empty slot, so it always counts as seen
                seen   = (sig == '0);
                stored = 1'b0;
                for (int k = 0; k < PROBES; k++)
                begin
                    if (!seen && !stored)
                    begin
                        probe = sig + k;
                        slot  = int'(probe % TABLE_N);
                        if (seen_sigs[slot] == sig)
                            seen = 1'b1;
                        else if (seen_sigs[slot] == '0)
                        begin
                            seen_sigs[slot] = sig;
                            stored          = 1'b1;
                        end
                    end
                end
                // every probe slot taken by others: evict the home slot
                if (!seen && !stored)
                    seen_sigs[int'(sig % TABLE_N)] = sig;
                if (!seen)
                begin
                    if (call_new < COUNT_MAX)
                        call_new = call_new + 1'b1;
                    fresh_edges.push_back('{sig, call_new});
                end
            end
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pc_backlog.size() > 0)
            begin
                nxt            = pc_backlog.pop_front();
                in_valid      <= 1'b1;
                pc            <= nxt.pc;
                first_of_call <= nxt.first;
                calm          <= nxt.quiet;
                if (!nxt.quiet && $urandom_range(0, 2) == 0)
                    in_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each output transaction, then decide whether to stall.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        new_edge_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (fresh_edges.size() == 0)
                begin
                    $error("unexpected transaction: signal %h new_count %0d",
                           signal, new_count);
                    mismatches++;
                end
                else
                begin
                    want = fresh_edges.pop_front();
                    if (signal !== want.sig)
                    begin
                        $error("signal: expected %h, actual %h", want.sig, signal);
                        mismatches++;
                    end
                    if (new_count !== want.cnt)
                    begin
                        $error("new_count: expected %0d, actual %0d", want.cnt, new_count);
                        mismatches++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall  = pick_gap() - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: give up when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [DATA_W-1:0] lib [LIB_N][LIB_LEN];
        int                lib_len [LIB_N];
        int                lib_used;
        logic [DATA_W-1:0] hot [8];
        logic [DATA_W-1:0] p;
        int                start;
        int                mode;
        int                n;
        int                j;
        int                cut;
        int                r;
        bit                quiet;

        lib_used = 0;
        hot[0] = '0;
        hot[1] = '1;
        hot[2] = 32'h0000_0001;
        hot[3] = 32'h8000_0000;
        for (int i = 4; i < 8; i++)
            hot[i] = $urandom();

        // Directed part.
        // zero signal at the start of a call, then a short call growing its count
        queue_pc('0, 1'b1, 1'b0);
        queue_pc('0, 1'b0, 1'b0);
        queue_pc('1, 1'b0, 1'b0);
        // pc equal to the hash of the one before: zero signal inside a call
        queue_pc(pc_hash('1), 1'b0, 1'b0);
        // all-ones signal: probes wrap round the end of the table; repeat is seen
        queue_pc('1, 1'b1, 1'b0);
        queue_pc('1, 1'b1, 1'b0);
        queue_pc(32'hFFFF_FFFE, 1'b1, 1'b0);
        // five signals sharing one home slot: fill the probe window, then evict
        for (int k = 1; k <= 5; k++)
            queue_pc(32'(k * TABLE_N + 5), 1'b1, 1'b0);
        // evicted signal comes back as new, one still held is seen
        queue_pc(32'(1 * TABLE_N + 5), 1'b1, 1'b0);
        queue_pc(32'(2 * TABLE_N + 5), 1'b1, 1'b0);
        queue_pc(32'(5 * TABLE_N + 5), 1'b1, 1'b0);
        // a longer call with alternating bit patterns
        queue_pc(32'h8000_0000, 1'b1, 1'b0);
        queue_pc(32'h0000_0001, 1'b0, 1'b0);
        queue_pc(32'h5555_5555, 1'b0, 1'b0);
        queue_pc(32'hAAAA_AAAA, 1'b0, 1'b0);
        queue_pc(32'h8000_0000, 1'b0, 1'b0);

        // Random part: mostly whole calls, many of them replays so that signals
        // are seen again; the rest is noise and calls with no clean start.
        start = queued_pcs;
        while (queued_pcs - start < RANDOM_PCS)
        begin
            quiet = ($urandom_range(0, 7) == 0);
            mode  = $urandom_range(0, 99);
            if (mode < 15)
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    p = ($urandom_range(0, 3) == 0) ? hot[$urandom_range(0, 7)] : $urandom();
                    queue_pc(p, ($urandom_range(0, 4) == 0), quiet);
                end
            end
            else if (mode < 60 && lib_used > 0)
            begin
                // replay a known call, sometimes with one pc swapped
                j   = $urandom_range(0, lib_used - 1);
                cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lib_len[j] - 1) : -1;
                for (int i = 0; i < lib_len[j]; i++)
                    queue_pc((i == cut) ? $urandom() : lib[j][i], (i == 0), quiet);
            end
            else
            begin
                if (lib_used < LIB_N)
                begin
                    j = lib_used;
                    lib_used++;
                end
                else
                    j = $urandom_range(0, LIB_N - 1);
                lib_len[j] = $urandom_range(2, LIB_LEN);
                for (int i = 0; i < lib_len[j]; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (i > 0 && r < 10)
                        lib[j][i] = pc_hash(lib[j][i - 1]);
                    else if (r < 35)
                        lib[j][i] = hot[$urandom_range(0, 7)];
                    else
                        lib[j][i] = $urandom();
                    queue_pc(lib[j][i], (i == 0), quiet);
                end
            end
        end

        // close with a short fresh call that restarts the count
        for (int i = 0; i < 6; i++)
            queue_pc($urandom(), (i == 0), 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_pcs == queued_pcs);
        wait (fresh_edges.size() == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
design/esh_pkg.sv
design/esh_table.sv
design/edge_signal_hash_dedup_top.sv
test/tb_top.sv
